// File: hdl/bdqs_pkg.sv
package bdqs_pkg;

   localparam int MODE_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;
   localparam int RSP_W    = 40;

   localparam logic [MODE_W-1:0] MODE_SEARCH     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd1;
   localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd4;
   localparam logic [MODE_W-1:0] MODE_REMOVE     = 3'd5;

   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_SHIFT,
      ST_POPW,
      ST_EMIT
   } dq_state_type;

endpackage

// File: hdl/bounded_deque_with_search.sv
// push front/back: write, then emit; pop front/back: read, then ST_POPW, then emit
// search: the scan reads one entry per cycle from the entry ram
// remove: the scan as for search, then one entry moved
// per cycle through the ram's separate read and write ports to close the gap
// one request at a time; a new request is taken while the last result still waits
// reset clears count, head pointer and control; ram contents stay undefined
module bounded_deque_with_search #(
   parameter int DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [bdqs_pkg::VALUE_W-1:0]   req_tdata,   // value[31:0]
   input  logic [bdqs_pkg::MODE_W-1:0]    req_tuser,   // mode[2:0]
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [bdqs_pkg::RSP_W-1:0]     rsp_tdata,   // popped[31:0], occupancy[36:32]
   output logic [bdqs_pkg::STATUS_W-1:0]  rsp_tuser    // status[1:0]
);

   import bdqs_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   dq_state_type state_ff, state_in;

   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       head_ff, head_in;
   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [VALUE_W-1:0]  value_ff, value_in;
   logic [CW-1:0]       nxt_ff, nxt_in;
   logic                rd_vld_ff, rd_vld_in;
   logic [CW-1:0]       rd_idx_ff, rd_idx_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [VALUE_W-1:0]  res_popped_ff, res_popped_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_W-1:0]    rsp_tdata_ff, rsp_tdata_in;
   logic [STATUS_W-1:0] rsp_tuser_ff, rsp_tuser_in;

   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   logic [VALUE_W-1:0]  ram_wdata;
   logic [AW-1:0]       ram_raddr;
   logic [VALUE_W-1:0]  ram_rdata;

   // logical position to ram address on the circular buffer
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] off);
      logic [AW:0] sum;
      sum = {1'b0, head} + (AW+1)'(off);
      if (sum >= (AW+1)'(DEPTH)) begin
         sum = sum - (AW+1)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   bdqs_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         head_ff       <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         head_ff       <= head_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      value_ff      <= value_in;
      nxt_ff        <= nxt_in;
      rd_idx_ff     <= rd_idx_in;
      res_status_ff <= res_status_in;
      res_popped_ff <= res_popped_in;
      rsp_tdata_ff  <= rsp_tdata_in;
      rsp_tuser_ff  <= rsp_tuser_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      head_in       = head_ff;
      mode_in       = mode_ff;
      value_in      = value_ff;
      nxt_in        = nxt_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = rd_idx_ff;
      res_status_in = res_status_ff;
      res_popped_in = res_popped_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = value_ff;
      ram_raddr     = '0;

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               mode_in  = req_tuser;
               value_in = req_tdata;
               state_in = ST_START;
            end
         end
         ST_START: begin
            res_status_in = STAT_OK;
            res_popped_in = '0;
            nxt_in        = '0;
            state_in      = ST_EMIT;
            unique case (mode_ff)
               MODE_SEARCH, MODE_REMOVE: begin
                  state_in = ST_SCAN;
               end
               MODE_PUSH_FRONT: begin
                  if (count_ff == CW'(DEPTH)) begin
                     res_status_in = STAT_FULL;
                  end else begin
                     head_in   = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);
                     ram_we    = 1'b1;
                     ram_waddr = head_in;
                     count_in  = count_ff + CW'(1);
                  end
               end
               MODE_PUSH_BACK: begin
                  if (count_ff == CW'(DEPTH)) begin
                     res_status_in = STAT_FULL;
                  end else begin
                     ram_we    = 1'b1;
                     ram_waddr = phys(head_ff, count_ff);
                     count_in  = count_ff + CW'(1);
                  end
               end
               MODE_POP_FRONT, MODE_POP_BACK: begin
                  if (count_ff == '0) begin
                     res_status_in = STAT_EMPTY;
                  end else begin
                     ram_raddr = (mode_ff == MODE_POP_FRONT) ? head_ff
                               : phys(head_ff, count_ff - CW'(1));
                     state_in  = ST_POPW;
                  end
               end
               default: begin
                  res_status_in = STAT_EMPTY;
               end
            endcase
         end
         ST_SCAN: begin
            if (rd_vld_ff && ram_rdata == value_ff) begin
               if (mode_ff == MODE_REMOVE) begin
                  // gap at rd_idx_ff, pull the tail down one place
                  nxt_in   = rd_idx_ff + CW'(1);
                  state_in = ST_SHIFT;
               end else begin
                  res_status_in = STAT_OK;
                  state_in      = ST_EMIT;
               end
            end else if (nxt_ff < count_ff) begin
               ram_raddr = phys(head_ff, nxt_ff);
               rd_vld_in = 1'b1;
               rd_idx_in = nxt_ff;
               nxt_in    = nxt_ff + CW'(1);
            end else if (!rd_vld_ff) begin
               res_status_in = STAT_EMPTY;
               state_in      = ST_EMIT;
            end
         end
         ST_SHIFT: begin
            // reads run one entry ahead of writes, so no forwarding is needed
            if (rd_vld_ff) begin
               ram_we    = 1'b1;
               ram_waddr = phys(head_ff, rd_idx_ff - CW'(1));
               ram_wdata = ram_rdata;
            end
            if (nxt_ff < count_ff) begin
               ram_raddr = phys(head_ff, nxt_ff);
               rd_vld_in = 1'b1;
               rd_idx_in = nxt_ff;
               nxt_in    = nxt_ff + CW'(1);
            end else if (!rd_vld_ff) begin
               count_in      = count_ff - CW'(1);
               res_status_in = STAT_OK;
               state_in      = ST_EMIT;
            end
         end
         ST_POPW: begin
            res_popped_in = ram_rdata;
            count_in      = count_ff - CW'(1);
            if (mode_ff == MODE_POP_FRONT) begin
               head_in = phys(head_ff, CW'(1));
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tuser_in  = res_status_ff;
               rsp_tdata_in  = {{(RSP_W - OCC_W - VALUE_W){1'b0}}, OCC_W'(count_ff),
                                res_popped_ff};
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

// File: hdl/bdqs_ram.sv
module bdqs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: tb/tb_bounded_deque_with_search.sv
`timescale 1ns / 100ps

module tb_bounded_deque_with_search;
   import bdqs_pkg::*;

   localparam int DEPTH        = 16;
   localparam int PHASE_ITEMS  = 320;
   localparam int HOLD_LEN     = 300;
   localparam int DRAIN_CYCLES = 60;
   localparam int STALL_LIMIT  = 5000;

   // modes with no operation behind them
   localparam logic [MODE_W-1:0] MODE_RSVD_6 = 3'd6;
   localparam logic [MODE_W-1:0] MODE_RSVD_7 = 3'd7;

   typedef struct {
      logic [MODE_W-1:0]  mode;
      logic [VALUE_W-1:0] value;
   } deque_req_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  popped;
      logic [OCC_W-1:0]    occupancy;
   } deque_rsp_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [VALUE_W-1:0]  req_tdata = '0;
   logic [MODE_W-1:0]   req_tuser = MODE_SEARCH;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_W-1:0]    rsp_tdata;
   logic [STATUS_W-1:0] rsp_tuser;

   deque_req_type      pending_reqs[$];
   deque_rsp_type      expected_rsps[$];
   logic [VALUE_W-1:0] held_words[$];
   logic [VALUE_W-1:0] value_pool[8];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_ask = 0;
   int hold_taken = 0;
   int hold_cnt = 0;
   int error_count = 0;
   int beats_in = 0;
   int beats_out = 0;
   int full_rejects = 0;
   int empty_pops = 0;
   int remove_hits = 0;
   int remove_misses = 0;
   int search_hits = 0;
   int peak_fill = 0;
   int quiet_cycles = 0;

   bounded_deque_with_search #(.DEPTH(DEPTH)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // index of the first held word equal to v, -1 when absent
   function automatic int locate_word(input logic [VALUE_W-1:0] v);
      for (int i = 0; i < held_words.size(); i++)
         if (held_words[i] == v)
            return i;
      return -1;
   endfunction

   function automatic deque_rsp_type apply_request(input deque_req_type rq);
      deque_rsp_type rs;
      int pos;
      rs.status = STAT_OK;
      rs.popped = '0;
      case (rq.mode)
         MODE_SEARCH: begin
            if (locate_word(rq.value) < 0)
               rs.status = STAT_EMPTY;
            else
               search_hits++;
         end
         MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
            if (held_words.size() >= DEPTH) begin
               rs.status = STAT_FULL;
               full_rejects++;
            end else if (rq.mode == MODE_PUSH_FRONT) begin
               held_words.push_front(rq.value);
            end else begin
               held_words.push_back(rq.value);
            end
         end
         MODE_POP_FRONT, MODE_POP_BACK: begin
            if (held_words.size() == 0) begin
               rs.status = STAT_EMPTY;
               empty_pops++;
            end else if (rq.mode == MODE_POP_FRONT) begin
               rs.popped = held_words.pop_front();
            end else begin
               rs.popped = held_words.pop_back();
            end
         end
         MODE_REMOVE: begin
            pos = locate_word(rq.value);
            if (pos < 0) begin
               rs.status = STAT_EMPTY;
               remove_misses++;
            end else begin
               held_words.delete(pos);
               remove_hits++;
            end
         end
         default: rs.status = STAT_EMPTY;
      endcase
      rs.occupancy = OCC_W'(held_words.size());
      if (held_words.size() > peak_fill)
         peak_fill = held_words.size();
      return rs;
   endfunction

   task automatic flag_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                input logic [VALUE_W-1:0] want);
      $display("%0t: MISMATCH %s: got %0h, expected %0h", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic add_req(input logic [MODE_W-1:0] m, input logic [VALUE_W-1:0] v);
      deque_req_type rq;
      rq.mode  = m;
      rq.value = v;
      pending_reqs.push_back(rq);
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      if ($urandom_range(99) < 65)
         return value_pool[$urandom_range(7)];
      return $urandom;
   endfunction

   // a run leans toward filling, draining or neither so both ends get reached
   task automatic add_random_run(input int n_items);
      int tilt;
      int r;
      logic [MODE_W-1:0] m;
      tilt = $urandom_range(2);
      for (int k = 0; k < n_items; k++) begin
         r = $urandom_range(99);
         if (r < 4)
            m = $urandom_range(1) ? MODE_RSVD_6 : MODE_RSVD_7;
         else if (r < 20)
            m = MODE_SEARCH;
         else if (r < 32)
            m = MODE_REMOVE;
         else if ((tilt == 0) ? (r < 82) : (tilt == 1) ? (r < 50) : (r < 66))
            m = $urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
         else
            m = $urandom_range(1) ? MODE_POP_FRONT : MODE_POP_BACK;
         add_req(m, pick_value());
      end
   endtask

   task automatic wait_drained();
      do
         @(negedge clock);
      while (pending_reqs.size() != 0 || req_tvalid || expected_rsps.size() != 0);
   endtask

   // request side
   always @(posedge clock) begin
      deque_req_type rq;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            rq.mode  = req_tuser;
            rq.value = req_tdata;
            expected_rsps.push_back(apply_request(rq));
            beats_in++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               rq = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= rq.mode;
               req_tdata  <= rq.value;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result side
   always @(posedge clock) begin
      deque_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            beats_out++;
            if (expected_rsps.size() == 0) begin
               $display("%0t: MISMATCH unexpected result beat", $realtime);
               error_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_tuser != want.status)
                  flag_mismatch("status", VALUE_W'(rsp_tuser), VALUE_W'(want.status));
               if (rsp_tdata[VALUE_W-1:0] != want.popped)
                  flag_mismatch("popped", rsp_tdata[VALUE_W-1:0], want.popped);
               if (rsp_tdata[VALUE_W +: OCC_W] != want.occupancy)
                  flag_mismatch("occupancy", VALUE_W'(rsp_tdata[VALUE_W +: OCC_W]),
                                VALUE_W'(want.occupancy));
               if (rsp_tdata[RSP_W-1:VALUE_W+OCC_W] != '0)
                  flag_mismatch("tdata padding", VALUE_W'(rsp_tdata[RSP_W-1:VALUE_W+OCC_W]),
                                '0);
            end
         end
         if (hold_cnt != 0) begin
            rsp_tready <= 1'b0;
            hold_cnt   <= hold_cnt - 1;
         end else if (hold_ask != hold_taken) begin
            hold_taken <= hold_ask;
            hold_cnt   <= HOLD_LEN;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int send_pcts[5];
      int recv_pcts[5];
      int queued;
      int run_len;
      send_pcts = '{0, 76, 0, 36, 0};
      recv_pcts = '{0, 0, 76, 36, 0};
      value_pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     $urandom, $urandom, $urandom, $urandom};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // corner cases on an empty list, at the value extremes and for reserved modes
      add_req(MODE_SEARCH, 32'h0000_0000);
      add_req(MODE_POP_FRONT, 32'hFFFF_FFFF);
      add_req(MODE_POP_BACK, 32'h1234_5678);
      add_req(MODE_REMOVE, 32'h0000_0000);
      add_req(MODE_RSVD_6, 32'hA5A5_A5A5);
      add_req(MODE_RSVD_7, 32'h5A5A_5A5A);
      add_req(MODE_PUSH_FRONT, 32'h8000_0000);
      add_req(MODE_PUSH_BACK, 32'h7FFF_FFFF);
      add_req(MODE_PUSH_BACK, 32'hFFFF_FFFF);
      add_req(MODE_SEARCH, 32'h7FFF_FFFF);
      add_req(MODE_SEARCH, 32'h0000_0000);
      add_req(MODE_REMOVE, 32'h8000_0000);
      add_req(MODE_REMOVE, 32'h1234_5678);
      add_req(MODE_PUSH_FRONT, 32'h0000_0000);
      add_req(MODE_POP_FRONT, 32'h0000_0000);
      add_req(MODE_POP_BACK, 32'h0000_0000);
      add_req(MODE_POP_BACK, 32'h0000_0000);
      add_req(MODE_SEARCH, 32'hFFFF_FFFF);
      wait_drained();

      for (int ph = 0; ph < 5; ph++) begin
         send_idle_pct  = send_pcts[ph];
         recv_stall_pct = recv_pcts[ph];
         // long receiver hold-off while requests keep coming
         if (ph == 0 || ph == 4)
            hold_ask++;
         queued = 0;
         while (queued < PHASE_ITEMS) begin
            run_len = $urandom_range(8, 40);
            add_random_run(run_len);
            queued += run_len;
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("covered %0d requests, %0d results; peak fill %0d of %0d",
               beats_in, beats_out, peak_fill, DEPTH);
      $display("full rejects %0d, empty pops %0d, removes hit/miss %0d/%0d, search hits %0d",
               full_rejects, empty_pops, remove_hits, remove_misses, search_hits);
      if (error_count == 0 && expected_rsps.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// File: sim.f
hdl/bdqs_pkg.sv
hdl/bdqs_ram.sv
hdl/bounded_deque_with_search.sv
tb/tb_bounded_deque_with_search.sv
